// ----- design/gwo_pkg.sv -----
`timescale 1ns / 1ps
// shared types, codes and helpers of the grey wolf optimizer engine
package gwo_pkg;

	localparam int POP_SIZE_DEF = 128;
	localparam int DIMENSIONS_DEF = 4;

	localparam logic [2:0] OP_LOAD   = 3'd0;
	localparam logic [2:0] OP_CLAMP  = 3'd1;
	localparam logic [2:0] OP_FIT    = 3'd2;
	localparam logic [2:0] OP_UPDATE = 3'd3;
	localparam logic [2:0] OP_END    = 3'd4;

	localparam logic [1:0] CFG_LOWER = 2'd0;
	localparam logic [1:0] CFG_UPPER = 2'd1;
	localparam logic [1:0] CFG_MAXIT = 2'd2;

	localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] S32_MIN = 32'sh80000000;
	localparam logic signed [31:0] FIT_INF = S32_MAX;
	localparam logic signed [31:0] LOWER_RST = -32'sd6553600;
	localparam logic signed [31:0] UPPER_RST = 32'sd6553600;
	localparam logic [15:0] MAXIT_RST = 16'd10;
	// ceil(2^33 / 3), exact quotient for dividends below 2^33
	localparam logic [31:0] RECIP3 = 32'haaaaaaab;

	localparam int DIV_W = 52;

	typedef struct packed {
		logic capture;
		logic pop_wr_load;
		logic pop_rd;
		logic clamp_wr;
		logic fit_upd;
		logic copy_rd;
		logic copy_wr;
		logic a_div_start;
		logic a_latch;
		logic lrd;
		logic m1;
		logic s2;
		logic m3;
		logic s4;
		logic sum_div_start;
		logic res_latch;
		logic iter_inc;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic item_ok;
		logic wolf_ok;
		logic fit_hit;
		logic copy_last;
		logic k_last;
		logic div_done;
	} dp_stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return S32_MAX;
		if (v < -64'sd2147483648) return S32_MIN;
		return v[31:0];
	endfunction

endpackage

// ----- design/gwo_req_if.sv -----
`timescale 1ns / 1ps
// request channel of the grey wolf optimizer engine
interface gwo_req_if;
	logic valid;
	logic ready;
	logic [2:0] opcode;
	logic [6:0] wolf_index;
	logic [1:0] dim_index;
	logic signed [31:0] operand_value;
	logic [15:0] rand_alpha_a;
	logic [15:0] rand_alpha_c;
	logic [15:0] rand_beta_a;
	logic [15:0] rand_beta_c;
	logic [15:0] rand_delta_a;
	logic [15:0] rand_delta_c;

	modport source (output valid, opcode, wolf_index, dim_index, operand_value,
		rand_alpha_a, rand_alpha_c, rand_beta_a, rand_beta_c, rand_delta_a, rand_delta_c,
		input ready);
	modport sink (input valid, opcode, wolf_index, dim_index, operand_value,
		rand_alpha_a, rand_alpha_c, rand_beta_a, rand_beta_c, rand_delta_a, rand_delta_c,
		output ready);
endinterface

// ----- design/gwo_rsp_if.sv -----
`timescale 1ns / 1ps
// response channel of the grey wolf optimizer engine
interface gwo_rsp_if;
	logic valid;
	logic ready;
	logic signed [31:0] result_value;
	logic signed [31:0] best_fitness;
	logic [15:0] iteration_count;
	logic run_done;

	modport source (output valid, result_value, best_fitness, iteration_count, run_done,
		input ready);
	modport sink (input valid, result_value, best_fitness, iteration_count, run_done,
		output ready);
endinterface

// ----- design/gwo_div.sv -----
`timescale 1ns / 1ps
// iterative restoring divider, one quotient bit per cycle
module gwo_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [gwo_pkg::DIV_W-1:0] dividend,
	input  logic [15:0] divisor,
	output logic done,
	output logic [gwo_pkg::DIV_W-1:0] quotient
);
	import gwo_pkg::*;

	localparam int CW = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] shr_q;
	logic [15:0] dvs_q;
	logic [15:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [16:0] rem_sh;
	logic [16:0] rem_sub;
	logic take;

	assign rem_sh = {rem_q, shr_q[DIV_W-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign take = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shr_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? rem_sub[15:0] : rem_sh[15:0];
			shr_q <= {shr_q[DIV_W-2:0], take};
		end
	end

	assign done = done_q;
	assign quotient = shr_q;

endmodule

// ----- design/gwo_dp.sv -----
`timescale 1ns / 1ps
// datapath: population and leader memories, fitness ranking, update arithmetic
module gwo_dp #(
	parameter int POP_SIZE = gwo_pkg::POP_SIZE_DEF,
	parameter int DIMENSIONS = gwo_pkg::DIMENSIONS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  gwo_pkg::dp_cmd_t cmd,
	output gwo_pkg::dp_stat_t stat,
	input  logic [2:0] opcode,
	input  logic [6:0] wolf_index,
	input  logic [1:0] dim_index,
	input  logic signed [31:0] operand_value,
	input  logic [15:0] rand_alpha_a,
	input  logic [15:0] rand_alpha_c,
	input  logic [15:0] rand_beta_a,
	input  logic [15:0] rand_beta_c,
	input  logic [15:0] rand_delta_a,
	input  logic [15:0] rand_delta_c,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [31:0] cfg_data,
	output logic signed [31:0] result_value,
	output logic signed [31:0] best_fitness,
	output logic [15:0] iteration_count,
	output logic run_done
);
	import gwo_pkg::*;

	localparam int POP_N = POP_SIZE * DIMENSIONS;
	localparam int PAW = $clog2(POP_N);
	localparam int PXW = PAW + 13;
	localparam int LDR_N = 3 * DIMENSIONS;
	localparam int LAW = $clog2(LDR_N);
	localparam int LXW = LAW + 8;
	localparam int JW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;

	logic signed [31:0] lb_q, ub_q;
	logic [15:0] maxit_q;
	logic [15:0] iter_q;

	logic [2:0] op_q;
	logic [6:0] w_q;
	logic [1:0] d_q;
	logic signed [31:0] val_q;
	logic [15:0] raa_q, rac_q, rba_q, rbc_q, rda_q, rdc_q;
	logic wolf_ok_q, item_ok_q;
	logic wolf_ok_in, item_ok_in;

	logic [JW-1:0] j_q;
	logic [1:0] k_q;
	logic [1:0] ck_q;

	logic signed [31:0] fit_q [3];
	logic hit0, hit1, hit2;

	logic [PXW-1:0] item_idx, copy_idx;
	logic [LXW-1:0] lrd_idx, lwr_idx;

	logic [31:0] pop_mem [POP_N];
	logic signed [31:0] pop_rd_q;
	logic pop_we;
	logic [31:0] pop_wd;
	logic [PAW-1:0] pop_ra;

	logic [31:0] ldr_mem [LDR_N];
	logic [LDR_N-1:0] ldr_vld_q;
	logic [31:0] ldr_rd_q;
	logic ldr_rv_q;
	logic signed [31:0] lv;

	logic signed [31:0] clamp_x;
	logic signed [31:0] res_q;
	logic signed [31:0] res_next;
	logic signed [31:0] a_q;
	logic [15:0] ra, rc;
	logic signed [31:0] lv_q;
	logic signed [48:0] p1_q;
	logic signed [49:0] p2_q;
	logic signed [31:0] coef_a_q;
	logic signed [31:0] dist_q;
	logic signed [63:0] p3_q;
	logic signed [51:0] sum_q;
	logic signed [63:0] dd;
	logic signed [63:0] dabs;
	logic [DIV_W-1:0] sum_mag;
	logic signed [63:0] q_s;
	logic sum_big;
	logic [64:0] quo_prod;
	logic [31:0] quo_q;
	logic signed [63:0] quo_s;

	logic div_start;
	logic [DIV_W-1:0] div_dvd;
	logic [15:0] div_dvs;
	logic div_done;
	logic [DIV_W-1:0] div_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lb_q <= LOWER_RST;
			ub_q <= UPPER_RST;
			maxit_q <= MAXIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LOWER: lb_q <= cfg_data;
				CFG_UPPER: ub_q <= cfg_data;
				CFG_MAXIT: maxit_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign wolf_ok_in = 32'(wolf_index) < 32'(POP_SIZE);
	assign item_ok_in = wolf_ok_in && (32'(dim_index) < 32'(DIMENSIONS));

	// captured request
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= opcode;
			w_q <= wolf_index;
			d_q <= dim_index;
			val_q <= operand_value;
			raa_q <= rand_alpha_a;
			rac_q <= rand_alpha_c;
			rba_q <= rand_beta_a;
			rbc_q <= rand_beta_c;
			rda_q <= rand_delta_a;
			rdc_q <= rand_delta_c;
			wolf_ok_q <= wolf_ok_in;
			item_ok_q <= item_ok_in;
		end
	end

	assign item_idx = PXW'(w_q) * PXW'(DIMENSIONS) + PXW'(d_q);
	assign copy_idx = PXW'(w_q) * PXW'(DIMENSIONS) + PXW'(j_q);
	assign lrd_idx = LXW'(k_q) * LXW'(DIMENSIONS) + LXW'(d_q);
	assign lwr_idx = LXW'(ck_q) * LXW'(DIMENSIONS) + LXW'(j_q);

	// population memory
	assign pop_we = cmd.pop_wr_load | cmd.clamp_wr | cmd.res_latch;
	assign pop_ra = cmd.copy_rd ? copy_idx[PAW-1:0] : item_idx[PAW-1:0];

	always_comb begin
		pop_wd = val_q;
		if (cmd.clamp_wr) pop_wd = clamp_x;
		else if (cmd.res_latch) pop_wd = res_next;
	end

	always_ff @(posedge clk) begin
		if (pop_we) pop_mem[item_idx[PAW-1:0]] <= pop_wd;
		if (cmd.pop_rd || cmd.copy_rd) pop_rd_q <= pop_mem[pop_ra];
	end

	// leader memory, entries read as zero until copied
	always_ff @(posedge clk) begin
		if (cmd.copy_wr) ldr_mem[lwr_idx[LAW-1:0]] <= pop_rd_q;
		if (cmd.lrd) ldr_rd_q <= ldr_mem[lrd_idx[LAW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ldr_vld_q <= '0;
			ldr_rv_q <= 1'b0;
		end else begin
			if (cmd.copy_wr) ldr_vld_q[lwr_idx[LAW-1:0]] <= 1'b1;
			if (cmd.lrd) ldr_rv_q <= ldr_vld_q[lrd_idx[LAW-1:0]];
		end
	end

	assign lv = ldr_rv_q ? $signed(ldr_rd_q) : '0;

	// fitness ranking
	assign hit0 = val_q < fit_q[0];
	assign hit1 = !hit0 && (val_q > fit_q[0]) && (val_q < fit_q[1]);
	assign hit2 = !hit0 && !hit1 && (val_q > fit_q[0]) && (val_q > fit_q[1])
		&& (val_q < fit_q[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_q[0] <= FIT_INF;
			fit_q[1] <= FIT_INF;
			fit_q[2] <= FIT_INF;
			iter_q <= '0;
		end else begin
			if (cmd.fit_upd) begin
				if (hit0) fit_q[0] <= val_q;
				else if (hit1) fit_q[1] <= val_q;
				else if (hit2) fit_q[2] <= val_q;
			end
			if (cmd.iter_inc && iter_q != 16'hffff) iter_q <= iter_q + 16'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fit_upd) ck_q <= hit0 ? 2'd0 : (hit1 ? 2'd1 : 2'd2);
		if (cmd.capture) j_q <= '0;
		else if (cmd.copy_wr) j_q <= j_q + JW'(1);
		if (cmd.capture) k_q <= '0;
		else if (cmd.s4) k_q <= k_q + 2'd1;
	end

	// clamp
	always_comb begin
		clamp_x = pop_rd_q;
		if (pop_rd_q > ub_q) clamp_x = ub_q;
		else if (pop_rd_q < lb_q) clamp_x = lb_q;
	end

	// divider for the decay of a
	assign div_start = cmd.a_div_start;
	assign div_dvd = DIV_W'({iter_q, 17'b0});
	assign div_dvs = (maxit_q == 16'd0) ? 16'd1 : maxit_q;

	gwo_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_q)
	);

	assign q_s = $signed({12'b0, div_q});

	// average over three leaders by reciprocal multiply, saturating at or above 2^33
	assign sum_mag = sum_q[51] ? DIV_W'(-sum_q) : DIV_W'(sum_q);
	assign sum_big = |sum_mag[DIV_W-1:33];
	assign quo_prod = 65'(sum_mag[32:0]) * 65'(RECIP3);
	assign quo_s = $signed({32'b0, quo_q});
	assign res_next = sum_big ? (sum_q[51] ? S32_MIN : S32_MAX)
		: sat32(sum_q[51] ? -quo_s : quo_s);

	always_comb begin
		case (k_q)
			2'd0: begin
				ra = raa_q;
				rc = rac_q;
			end
			2'd1: begin
				ra = rba_q;
				rc = rbc_q;
			end
			default: begin
				ra = rda_q;
				rc = rdc_q;
			end
		endcase
	end

	assign dd = 64'(p2_q >>> 16) - 64'(pop_rd_q);
	assign dabs = dd[63] ? -dd : dd;

	// leader pull arithmetic
	always_ff @(posedge clk) begin
		if (cmd.capture) res_q <= '0;
		else if (cmd.clamp_wr) res_q <= clamp_x;
		else if (cmd.res_latch) res_q <= res_next;
		if (cmd.a_latch) a_q <= sat32(64'sd131072 - q_s);
		if (cmd.m1) begin
			lv_q <= lv;
			p1_q <= a_q * $signed({1'b0, ra});
			p2_q <= $signed({1'b0, rc, 1'b0}) * lv;
		end
		if (cmd.s2) begin
			coef_a_q <= sat32(64'(p1_q >>> 15) - 64'(a_q));
			dist_q <= (dabs > 64'sd2147483647) ? S32_MAX : dabs[31:0];
		end
		if (cmd.m3) p3_q <= coef_a_q * dist_q;
		if (cmd.capture) sum_q <= '0;
		else if (cmd.s4) sum_q <= sum_q + 52'(64'(lv_q) - (p3_q >>> 16));
		if (cmd.sum_div_start) quo_q <= quo_prod[64:33];
	end

	// response register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_value <= res_q;
			best_fitness <= fit_q[0];
			iteration_count <= iter_q;
			run_done <= iter_q >= maxit_q;
		end
	end

	assign stat.op = op_q;
	assign stat.item_ok = item_ok_q;
	assign stat.wolf_ok = wolf_ok_q;
	assign stat.fit_hit = hit0 | hit1 | hit2;
	assign stat.copy_last = 32'(j_q) == DIMENSIONS - 1;
	assign stat.k_last = k_q == 2'd2;
	assign stat.div_done = div_done;

endmodule

// ----- design/gwo_ctrl.sv -----
`timescale 1ns / 1ps
// controller state machine sequencing each request through the datapath
module gwo_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output gwo_pkg::dp_cmd_t cmd,
	input  gwo_pkg::dp_stat_t stat
);
	import gwo_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_CLAMP  = 4'd2;
	localparam logic [3:0] S_FITCMP = 4'd3;
	localparam logic [3:0] S_CPRD   = 4'd4;
	localparam logic [3:0] S_CPWR   = 4'd5;
	localparam logic [3:0] S_ADIV   = 4'd6;
	localparam logic [3:0] S_LRD    = 4'd7;
	localparam logic [3:0] S_M1     = 4'd8;
	localparam logic [3:0] S_S2     = 4'd9;
	localparam logic [3:0] S_M3     = 4'd10;
	localparam logic [3:0] S_S4     = 4'd11;
	localparam logic [3:0] S_SDST   = 4'd12;
	localparam logic [3:0] S_SDIV   = 4'd13;
	localparam logic [3:0] S_FIN    = 4'd14;

	logic [3:0] state_q, nxt;
	logic out_valid_q;

	always_comb begin
		cmd = '0;
		nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					nxt = S_DECODE;
				end
			end
			S_DECODE: begin
				nxt = S_FIN;
				unique case (stat.op)
					OP_LOAD: cmd.pop_wr_load = stat.item_ok;
					OP_CLAMP: begin
						if (stat.item_ok) begin
							cmd.pop_rd = 1'b1;
							nxt = S_CLAMP;
						end
					end
					OP_FIT: begin
						if (stat.wolf_ok) nxt = S_FITCMP;
					end
					OP_UPDATE: begin
						if (stat.item_ok) begin
							cmd.pop_rd = 1'b1;
							cmd.a_div_start = 1'b1;
							nxt = S_ADIV;
						end
					end
					OP_END: cmd.iter_inc = 1'b1;
					default: ;
				endcase
			end
			S_CLAMP: begin
				cmd.clamp_wr = 1'b1;
				nxt = S_FIN;
			end
			S_FITCMP: begin
				if (stat.fit_hit) begin
					cmd.fit_upd = 1'b1;
					nxt = S_CPRD;
				end else begin
					nxt = S_FIN;
				end
			end
			S_CPRD: begin
				cmd.copy_rd = 1'b1;
				nxt = S_CPWR;
			end
			S_CPWR: begin
				cmd.copy_wr = 1'b1;
				nxt = stat.copy_last ? S_FIN : S_CPRD;
			end
			S_ADIV: begin
				if (stat.div_done) begin
					cmd.a_latch = 1'b1;
					nxt = S_LRD;
				end
			end
			S_LRD: begin
				cmd.lrd = 1'b1;
				nxt = S_M1;
			end
			S_M1: begin
				cmd.m1 = 1'b1;
				nxt = S_S2;
			end
			S_S2: begin
				cmd.s2 = 1'b1;
				nxt = S_M3;
			end
			S_M3: begin
				cmd.m3 = 1'b1;
				nxt = S_S4;
			end
			S_S4: begin
				cmd.s4 = 1'b1;
				nxt = stat.k_last ? S_SDST : S_LRD;
			end
			S_SDST: begin
				cmd.sum_div_start = 1'b1;
				nxt = S_SDIV;
			end
			S_SDIV: begin
				cmd.res_latch = 1'b1;
				nxt = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					nxt = S_IDLE;
				end
			end
			default: nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= nxt;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign in_ready = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == S_DECODE)
		else $error("accepted request not decoded");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.out_load && out_valid_q && !out_ready))
		else $error("pending response overwritten");

	a_div_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.a_div_start || cmd.sum_div_start) |=> !stat.div_done)
		else $error("divider done right after start");

endmodule

// ----- design/grey_wolf_optimizer_engine.sv -----
`timescale 1ns / 1ps
// top level of the grey wolf optimizer engine
//
//   channel  direction  handshake        payload
//   req      in         valid/ready      opcode, indexes, operand, six fractions
//   rsp      out        valid/ready      result, best fitness, iterations, done
//   cfg      in         cfg_we           cfg_index, cfg_data
//
// one request at a time; load, end and ignored requests go from decode to the final state,
// clamp adds a write of the clamped value, a fitness report a copy read and write per
// dimension when a leader is replaced; update waits on the one-bit-per-cycle divider for a,
// runs the three leader passes and a reciprocal divide by three
// reset clears control, leader fitnesses to the maximum and leader positions to zero
// a response held by rsp.ready keeps the engine in its final state
module grey_wolf_optimizer_engine #(
	parameter int POP_SIZE = gwo_pkg::POP_SIZE_DEF,
	parameter int DIMENSIONS = gwo_pkg::DIMENSIONS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	gwo_req_if.sink req,
	gwo_rsp_if.source rsp,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [31:0] cfg_data
);
	import gwo_pkg::*;

	dp_cmd_t cmd;
	dp_stat_t stat;

	gwo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	gwo_dp #(
		.POP_SIZE   (POP_SIZE),
		.DIMENSIONS (DIMENSIONS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.opcode          (req.opcode),
		.wolf_index      (req.wolf_index),
		.dim_index       (req.dim_index),
		.operand_value   (req.operand_value),
		.rand_alpha_a    (req.rand_alpha_a),
		.rand_alpha_c    (req.rand_alpha_c),
		.rand_beta_a     (req.rand_beta_a),
		.rand_beta_c     (req.rand_beta_c),
		.rand_delta_a    (req.rand_delta_a),
		.rand_delta_c    (req.rand_delta_c),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.result_value    (rsp.result_value),
		.best_fitness    (rsp.best_fitness),
		.iteration_count (rsp.iteration_count),
		.run_done        (rsp.run_done)
	);

endmodule
